// ----- hw/rtl/pltt_pkg.sv -----
// ============================================================================
// pltt_pkg - shared types and constants for the peer liveness timeout table
// Field widths, command codes, sequencer states and default parameters.
// ============================================================================
package pltt_pkg;

    // Fixed payload widths
    localparam int CMD_W     = 2;
    localparam int NODE_W    = 8;
    localparam int TIME_IN_W = 32;
    localparam int CNT_W     = 9;
    localparam int TMO_W     = 16;

    // Parameter defaults
    localparam int NODE_SLOTS_DEF = 256;
    localparam int TIME_BITS_DEF  = 32;

    // Timeout register reset value (seconds)
    localparam logic [TMO_W-1:0] TMO_RST = 16'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE = 2'd0,
        CMD_SWEEP  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN
    } t_state;

endpackage

// ----- hw/rtl/pltt_if.sv -----
// ============================================================================
// pltt_if - request and response channels of the peer liveness timeout table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface pltt_req_if;
    logic                            valid;
    logic                            ready;
    logic [pltt_pkg::CMD_W-1:0]      command;
    logic [pltt_pkg::NODE_W-1:0]     node_id;
    logic [pltt_pkg::TIME_IN_W-1:0]  time_value;

    modport source (output valid, command, node_id, time_value, input ready);
    modport sink   (input valid, command, node_id, time_value, output ready);
endinterface

interface pltt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        peer_lost;
    logic [pltt_pkg::CNT_W-1:0]  removed_count;
    logic [pltt_pkg::CNT_W-1:0]  live_count;

    modport source (output valid, peer_lost, removed_count, live_count, input ready);
    modport sink   (input valid, peer_lost, removed_count, live_count, output ready);
endinterface

// ----- hw/rtl/peer_liveness_timeout_table.sv -----
// ============================================================================
// peer_liveness_timeout_table - heartbeat table with timeout sweep
// One slot per node ID holds a live bit and the last heard timestamp. Sweeps
// walk the table one slot per cycle through a single subtract/compare unit.
// ============================================================================
//
//  channel   dir  handshake       payload
//  -------   ---  -------------   -------------------------------------------
//  i_req     in   valid / ready   command, node_id, time_value
//  o_rsp     out  valid / ready   peer_lost, removed_count, live_count
//  i_cfg     in   i_cfg_we        i_cfg_wdata (lost_timeout, seconds)
//
//  Update, clear and unused codes: result registered next cycle.
//  Sweep: the slot timestamp RAM read port, one slot per cycle, sets the pace
//  (registered read, then age compare); the drain state posts the result.
//  A new request is taken in idle as soon as the result register is free or
//  is being drained in the same cycle; a stalled o_rsp holds further requests.
//  Reset clears all live bits, the lost flag, the live count and restores the
//  timeout to 5 s; the timestamp RAM is not cleared (it only counts for live slots).
//
module peer_liveness_timeout_table #(
    parameter int NODE_SLOTS = pltt_pkg::NODE_SLOTS_DEF,
    parameter int TIME_BITS  = pltt_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pltt_req_if.sink                     i_req,
    pltt_rsp_if.source                   o_rsp,
    input  logic                         i_cfg_we,
    input  logic [pltt_pkg::TMO_W-1:0]   i_cfg_wdata
);

    localparam int IW = $clog2(NODE_SLOTS);
    localparam int CW = pltt_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0]        r_mem [NODE_SLOTS];   // last heard timestamps
    logic [TIME_BITS-1:0]        r_rd_data;            // registered RAM read
    logic [NODE_SLOTS-1:0]       r_live, n_live;       // slot valid bits

    // Control and sweep state
    pltt_pkg::t_state            r_state, n_state;
    logic [IW-1:0]               r_rd_idx, n_rd_idx;   // RAM read address
    logic [IW-1:0]               r_cmp_idx, n_cmp_idx; // slot in compare stage
    logic                        r_cmp_vld, n_cmp_vld;
    logic [TIME_BITS-1:0]        r_now, n_now;         // sweep current time
    logic [CW-1:0]               r_removed, n_removed;
    logic [CW-1:0]               r_live_total, n_live_total;
    logic                        r_lost, n_lost;
    logic [pltt_pkg::TMO_W-1:0]  r_lost_timeout;

    // Result register
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_lost, n_out_lost;
    logic [CW-1:0]               r_out_removed, n_out_removed;
    logic [CW-1:0]               r_out_live, n_out_live;

    // Datapath
    logic [63:0]                 w_tv_ext;
    logic [TIME_BITS-1:0]        w_tv;
    logic [TIME_BITS-1:0]        w_age;
    logic                        w_hit;
    logic [CW-1:0]               w_removed_sum;
    logic                        w_req_xfer;
    logic                        w_node_ok;
    logic [IW-1:0]               w_node_idx;
    logic                        w_mem_we;

    // Time is taken modulo 2^TIME_BITS
    assign w_tv_ext   = {32'd0, i_req.time_value};
    assign w_tv       = w_tv_ext[TIME_BITS-1:0];
    assign w_node_ok  = ({1'b0, i_req.node_id} < CW'(NODE_SLOTS));
    assign w_node_idx = i_req.node_id[IW-1:0];

    assign i_req.ready = (r_state == pltt_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_req_xfer  = i_req.valid && i_req.ready;
    assign w_mem_we    = w_req_xfer && (i_req.command == pltt_pkg::CMD_UPDATE) && w_node_ok;

    // Shared age unit: wrapping subtract and compare against the timeout
    assign w_age         = r_now - r_rd_data;
    assign w_hit         = r_cmp_vld && r_live[r_cmp_idx]
                           && (w_age > TIME_BITS'(r_lost_timeout));
    assign w_removed_sum = r_removed + CW'(w_hit);

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.peer_lost     = r_out_lost;
    assign o_rsp.removed_count = r_out_removed;
    assign o_rsp.live_count    = r_out_live;

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_live        = r_live;
        n_rd_idx      = r_rd_idx;
        n_cmp_idx     = r_rd_idx;
        n_cmp_vld     = 1'b0;
        n_now         = r_now;
        n_removed     = r_removed;
        n_live_total  = r_live_total;
        n_lost        = r_lost;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_lost    = r_out_lost;
        n_out_removed = r_out_removed;
        n_out_live    = r_out_live;

        // compare stage retires one slot per cycle
        if (w_hit) begin
            n_live[r_cmp_idx] = 1'b0;
        end

        case (r_state)
            pltt_pkg::S_IDLE: begin
                if (w_req_xfer) begin
                    case (i_req.command)
                        pltt_pkg::CMD_UPDATE: begin
                            if (w_node_ok && !r_live[w_node_idx]) begin
                                n_live[w_node_idx] = 1'b1;
                                n_live_total       = r_live_total + CW'(1);
                            end
                            n_out_valid   = 1'b1;
                            n_out_lost    = r_lost;
                            n_out_removed = '0;
                            n_out_live    = n_live_total;
                        end
                        pltt_pkg::CMD_SWEEP: begin
                            n_state   = pltt_pkg::S_SWEEP;
                            n_rd_idx  = '0;
                            n_now     = w_tv;
                            n_removed = '0;
                        end
                        pltt_pkg::CMD_CLEAR: begin
                            n_lost        = 1'b0;
                            n_out_valid   = 1'b1;
                            n_out_lost    = 1'b0;
                            n_out_removed = '0;
                            n_out_live    = r_live_total;
                        end
                        default: begin
                            // unused code: report only
                            n_out_valid   = 1'b1;
                            n_out_lost    = r_lost;
                            n_out_removed = '0;
                            n_out_live    = r_live_total;
                        end
                    endcase
                end
            end
            pltt_pkg::S_SWEEP: begin
                n_cmp_vld = 1'b1;
                n_removed = w_removed_sum;
                if (r_rd_idx == IW'(NODE_SLOTS - 1)) begin
                    n_state = pltt_pkg::S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + IW'(1);
                end
            end
            pltt_pkg::S_DRAIN: begin
                // last slot leaves the compare stage; result register is free
                n_state       = pltt_pkg::S_IDLE;
                n_removed     = w_removed_sum;
                n_live_total  = r_live_total - w_removed_sum;
                n_lost        = r_lost || (w_removed_sum != '0);
                n_out_valid   = 1'b1;
                n_out_lost    = n_lost;
                n_out_removed = w_removed_sum;
                n_out_live    = n_live_total;
            end
            default: begin
                n_state = pltt_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= pltt_pkg::S_IDLE;
            r_live         <= '0;
            r_cmp_vld      <= 1'b0;
            r_live_total   <= '0;
            r_lost         <= 1'b0;
            r_lost_timeout <= pltt_pkg::TMO_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_live       <= n_live;
            r_cmp_vld    <= n_cmp_vld;
            r_live_total <= n_live_total;
            r_lost       <= n_lost;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_lost_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx      <= n_rd_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_now         <= n_now;
        r_removed     <= n_removed;
        r_out_lost    <= n_out_lost;
        r_out_removed <= n_out_removed;
        r_out_live    <= n_out_live;
    end

    // Timestamp RAM: one write port (updates), one registered read (sweep)
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_node_idx] <= w_tv;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_live_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live_total <= CW'(NODE_SLOTS))
        else $error("live count above table size");

    a_sweep_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_xfer && (i_req.command == pltt_pkg::CMD_SWEEP))
        |=> (r_state == pltt_pkg::S_SWEEP) && (r_rd_idx == '0))
        else $error("sweep did not start at slot zero");

    a_drain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pltt_pkg::S_DRAIN) |=> o_rsp.valid && (r_state == pltt_pkg::S_IDLE))
        else $error("sweep end did not post a result");

    a_idle_no_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pltt_pkg::S_IDLE) |-> !r_cmp_vld)
        else $error("compare stage busy while idle");

    a_removed_sets_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.removed_count == '0) || o_rsp.peer_lost)
        else $error("slots removed without lost flag");
`endif

endmodule
